/* hw/rtl/awm_pkg.sv */
package awm_pkg;

  localparam int unsigned SYM_W  = 8;
  localparam int unsigned OP_W   = 2;
  localparam int unsigned LEN_W  = 9;
  localparam int unsigned BAL_W  = 10;
  localparam int unsigned SUM_W  = 10;
  localparam int unsigned SEEN_W = 9;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 9'd511;
  localparam logic [CNT_W-1:0]  CNT_MAX  = 32'hFFFF_FFFF;
  localparam logic signed [BAL_W:0] BAL_HI = 11'sd511;
  localparam logic signed [BAL_W:0] BAL_LO = -11'sd512;
  localparam logic signed [SUM_W+1:0] SUM_HI = 12'sd1023;

  // register index as seen in paddr[ADDR_W-1:2]
  localparam logic REG_PATTERN_LENGTH = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_PATTERN = 2'd1,
    OP_TEXT    = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    UK_NOP = 2'd0,
    UK_ADJ = 2'd1,
    UK_CLR = 2'd2
  } uop_kind_t;

  typedef logic signed [BAL_W-1:0] bal_t;
  typedef logic [SUM_W-1:0]        sum_t;

  // one count-table operation handed from the sequencer to the count unit
  typedef struct packed {
    logic             valid;
    uop_kind_t        kind;
    logic [SYM_W-1:0] idx;
    logic             inc;         // 1: add one, 0: subtract one
    logic             last;        // last operation of its transaction
    logic             is_text;
    logic             full_after;
  } uop_t;

  function automatic sum_t mag(bal_t v);
    logic [BAL_W-1:0] u;
    u = v;
    return v[BAL_W-1] ? SUM_W'(~u + 1'b1) : SUM_W'(u);
  endfunction

endpackage

/* hw/rtl/awm_in_if.sv */
interface awm_in_if;
  logic                          valid;
  logic                          ready;
  logic [awm_pkg::OP_W-1:0]      operation;
  logic [awm_pkg::SYM_W-1:0]     symbol;

  modport source (output valid, operation, symbol, input ready);
  modport sink   (input valid, operation, symbol, output ready);
endinterface

/* hw/rtl/awm_out_if.sv */
interface awm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          match;
  logic                          window_full;
  logic [awm_pkg::CNT_W-1:0]     match_count;

  modport source (output valid, match, window_full, match_count, input ready);
  modport sink   (input valid, match, window_full, match_count, output ready);
endinterface

/* hw/rtl/awm_ram.sv */
module awm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/awm_sequencer.sv */
module awm_sequencer #(
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned WINDOW_MAX = 256,
  localparam int unsigned WA = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  awm_in_if.sink                      in_ch,
  input  logic [awm_pkg::LEN_W-1:0]   pattern_length,
  output awm_pkg::uop_t               uop,
  input  logic                        uop_ready
);

  typedef logic [awm_pkg::SYM_W-1:0] sym_tbl_t [256];

  function automatic sym_tbl_t build_mod_tbl();
    sym_tbl_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = awm_pkg::SYM_W'(i % ALPHABET_SIZE);
    end
    return t;
  endfunction

  localparam sym_tbl_t MOD_TBL = build_mod_tbl();
  localparam logic [WA:0]   WIN_DEPTH = (WA + 1)'(WINDOW_MAX);
  localparam logic [WA-1:0] HEAD_LAST = WA'(WINDOW_MAX - 1);

  logic                          accept;
  logic                          is_text;
  logic [awm_pkg::LEN_W-1:0]     eff_len;
  logic                          full_before;
  logic                          full_after;
  logic [awm_pkg::SEEN_W-1:0]    seen_r, seen_nxt;
  logic [WA-1:0]                 head_r, head_nxt;
  logic [WA:0]                   pos_sum;
  logic [WA-1:0]                 pos;
  logic [awm_pkg::SYM_W-1:0]     sym_idx;
  logic [awm_pkg::SYM_W-1:0]     win_q;

  logic                          f1_valid_r;
  logic [awm_pkg::OP_W-1:0]      f1_op_r;
  logic [awm_pkg::SYM_W-1:0]     f1_idx_r;
  logic                          f1_leave_r;
  logic                          f1_full_r;
  logic                          f1_phase_r;
  logic                          final_emit;
  logic                          f1_done;

  assign accept  = in_ch.valid && in_ch.ready;
  assign is_text = (in_ch.operation == awm_pkg::OP_TEXT);
  assign sym_idx = MOD_TBL[in_ch.symbol];

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = awm_pkg::LEN_W'(1);
    end else if (32'(pattern_length) > WINDOW_MAX) begin
      eff_len = awm_pkg::LEN_W'(WINDOW_MAX);
    end else begin
      eff_len = pattern_length;
    end
  end

  assign full_before = (seen_r >= eff_len);

  always_comb begin
    seen_nxt = seen_r;
    head_nxt = head_r;
    unique case (in_ch.operation)
      awm_pkg::OP_CLEAR: begin
        seen_nxt = '0;
        head_nxt = '0;
      end
      awm_pkg::OP_TEXT: begin
        if (seen_r != awm_pkg::SEEN_MAX) begin
          seen_nxt = seen_r + 1'b1;
        end
        head_nxt = (head_r == HEAD_LAST) ? '0 : head_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign full_after = (seen_nxt >= eff_len);

  // slot of the symbol that leaves the window
  always_comb begin
    pos_sum = {1'b0, head_r} + (WA + 1)'(WINDOW_MAX - 32'(eff_len));
    if (pos_sum >= WIN_DEPTH) begin
      pos_sum = pos_sum - WIN_DEPTH;
    end
    pos = pos_sum[WA-1:0];
  end

  awm_ram #(
    .WIDTH (awm_pkg::SYM_W),
    .DEPTH (WINDOW_MAX)
  ) u_window (
    .clk   (clk),
    .we    (accept && is_text),
    .waddr (head_r),
    .wdata (sym_idx),
    .re    (accept && is_text),
    .raddr (pos),
    .rdata (win_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      head_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
      head_r <= head_nxt;
    end
  end

  always_comb begin
    uop        = '0;
    final_emit = 1'b0;
    if (f1_valid_r) begin
      uop.valid      = 1'b1;
      uop.is_text    = (f1_op_r == awm_pkg::OP_TEXT);
      uop.full_after = f1_full_r;
      if (f1_leave_r && !f1_phase_r) begin
        uop.kind = awm_pkg::UK_ADJ;
        uop.idx  = win_q;
        uop.inc  = 1'b1;
      end else begin
        uop.last   = 1'b1;
        final_emit = 1'b1;
        unique case (f1_op_r)
          awm_pkg::OP_CLEAR: begin
            uop.kind = awm_pkg::UK_CLR;
          end
          awm_pkg::OP_PATTERN: begin
            uop.kind = awm_pkg::UK_ADJ;
            uop.idx  = f1_idx_r;
            uop.inc  = 1'b1;
          end
          awm_pkg::OP_TEXT: begin
            uop.kind = awm_pkg::UK_ADJ;
            uop.idx  = f1_idx_r;
            uop.inc  = 1'b0;
          end
          default: begin
            uop.kind = awm_pkg::UK_NOP;
          end
        endcase
      end
    end
  end

  assign f1_done     = final_emit && uop_ready;
  assign in_ch.ready = !f1_valid_r || f1_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f1_phase_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= 1'b1;
      f1_phase_r <= 1'b0;
    end else if (f1_done) begin
      f1_valid_r <= 1'b0;
    end else if (f1_valid_r && uop_ready) begin
      f1_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_op_r    <= in_ch.operation;
      f1_idx_r   <= sym_idx;
      f1_leave_r <= is_text && full_before;
      f1_full_r  <= full_after;
    end
  end

endmodule

/* hw/rtl/awm_count_unit.sv */
module awm_count_unit #(
  parameter int unsigned ALPHABET_SIZE = 256,
  localparam int unsigned AA = $clog2(ALPHABET_SIZE)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  awm_pkg::uop_t  uop,
  output logic           uop_ready,
  awm_out_if.source      out_ch
);

  logic                           take;
  logic                           stall;
  logic                           fire;
  logic                           m_valid_r;
  awm_pkg::uop_t                  m_uop_r;
  logic [AA-1:0]                  m_idx;
  awm_pkg::bal_t                  ram_q;
  logic [ALPHABET_SIZE-1:0]       valid_r;
  logic                           fwd_valid_r;
  logic [AA-1:0]                  fwd_idx_r;
  awm_pkg::bal_t                  fwd_val_r;
  awm_pkg::bal_t                  cur;
  awm_pkg::bal_t                  new_bal;
  logic signed [awm_pkg::BAL_W:0] bal_sum;
  logic signed [awm_pkg::SUM_W+1:0] abs_calc;
  awm_pkg::sum_t                  abs_r, abs_nxt;
  logic [awm_pkg::CNT_W-1:0]      matches_r, matches_nxt;
  logic                           hit;
  logic                           out_valid_r;

  assign take      = uop.valid && uop_ready;
  assign stall     = m_valid_r && m_uop_r.last && out_valid_r && !out_ch.ready;
  assign uop_ready = !stall;
  assign fire      = m_valid_r && !stall;
  assign m_idx     = m_uop_r.idx[AA-1:0];

  awm_ram #(
    .WIDTH (awm_pkg::BAL_W),
    .DEPTH (ALPHABET_SIZE)
  ) u_counts (
    .clk   (clk),
    .we    (fire && (m_uop_r.kind == awm_pkg::UK_ADJ)),
    .waddr (m_idx),
    .wdata (new_bal),
    .re    (take && (uop.kind == awm_pkg::UK_ADJ)),
    .raddr (uop.idx[AA-1:0]),
    .rdata (ram_q)
  );

  // last written entry wins, then the memory, then the cleared value
  always_comb begin
    if (fwd_valid_r && (fwd_idx_r == m_idx)) begin
      cur = fwd_val_r;
    end else if (valid_r[m_idx]) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
  end

  always_comb begin
    bal_sum = {cur[awm_pkg::BAL_W-1], cur} + (m_uop_r.inc ? 11'sd1 : -11'sd1);
    if (bal_sum > awm_pkg::BAL_HI) begin
      new_bal = awm_pkg::BAL_HI[awm_pkg::BAL_W-1:0];
    end else if (bal_sum < awm_pkg::BAL_LO) begin
      new_bal = awm_pkg::BAL_LO[awm_pkg::BAL_W-1:0];
    end else begin
      new_bal = bal_sum[awm_pkg::BAL_W-1:0];
    end
  end

  always_comb begin
    abs_calc = $signed({2'b00, abs_r}) - $signed({2'b00, awm_pkg::mag(cur)})
             + $signed({2'b00, awm_pkg::mag(new_bal)});
    unique case (m_uop_r.kind)
      awm_pkg::UK_ADJ: begin
        if (abs_calc < 0) begin
          abs_nxt = '0;
        end else if (abs_calc > awm_pkg::SUM_HI) begin
          abs_nxt = awm_pkg::SUM_HI[awm_pkg::SUM_W-1:0];
        end else begin
          abs_nxt = abs_calc[awm_pkg::SUM_W-1:0];
        end
      end
      awm_pkg::UK_CLR: abs_nxt = '0;
      default:         abs_nxt = abs_r;
    endcase
  end

  assign hit = m_uop_r.last && m_uop_r.is_text && m_uop_r.full_after
            && (m_uop_r.kind == awm_pkg::UK_ADJ) && (abs_nxt == '0);

  always_comb begin
    if (m_uop_r.kind == awm_pkg::UK_CLR) begin
      matches_nxt = '0;
    end else if (hit && (matches_r != awm_pkg::CNT_MAX)) begin
      matches_nxt = matches_r + 1'b1;
    end else begin
      matches_nxt = matches_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= take || stall;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_uop_r <= uop;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fwd_valid_r <= 1'b0;
      abs_r       <= '0;
      matches_r   <= '0;
    end else if (fire) begin
      abs_r     <= abs_nxt;
      matches_r <= matches_nxt;
      unique case (m_uop_r.kind)
        awm_pkg::UK_ADJ: begin
          valid_r[m_idx] <= 1'b1;
          fwd_valid_r    <= 1'b1;
        end
        awm_pkg::UK_CLR: begin
          valid_r     <= '0;
          fwd_valid_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && (m_uop_r.kind == awm_pkg::UK_ADJ)) begin
      fwd_idx_r <= m_idx;
      fwd_val_r <= new_bal;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && m_uop_r.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && m_uop_r.last) begin
      out_ch.match       <= hit;
      out_ch.window_full <= m_uop_r.full_after;
      out_ch.match_count <= matches_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;

endmodule

/* hw/rtl/abelian_window_matcher_unit.sv */
// abelian (permutation) window matcher: send a clear transaction, then the
// pattern bytes, then the text bytes; every input transaction returns one
// result transaction, and a text byte flags match when the last
// pattern_length text bytes are a permutation of the pattern. clear,
// pattern and unused-code transactions are taken one per cycle while the
// output is not held; a text byte needs one count-table operation until the
// window is full and two after that, since the leaving and the entering
// symbol each need a read-modify-write of the per-symbol count table, which
// has a single write port. a result passes the sequencer register and the
// count-unit register and sits in an output register, so new input keeps
// flowing while it waits, until the next result is ready. the count
// table is cleared at once by per-entry valid bits, so the block is ready
// right after reset and after a clear. pattern_length is written through
// the apb port at byte address 0 and must only change while the block is
// idle
module abelian_window_matcher_unit #(
  parameter int unsigned ALPHABET_SIZE = 256,
  parameter int unsigned WINDOW_MAX    = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  awm_in_if.sink                        in_ch,
  awm_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [awm_pkg::ADDR_W-1:0]    paddr,
  input  logic [awm_pkg::DATA_W-1:0]    pwdata,
  output logic [awm_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  logic [awm_pkg::LEN_W-1:0] pattern_length_r;
  logic                      reg_sel;
  awm_pkg::uop_t             uop;
  logic                      uop_ready;

  // apb register file: one register, no wait states
  assign pready  = 1'b1;
  assign reg_sel = (paddr[awm_pkg::ADDR_W-1:2] == awm_pkg::REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_length_r <= awm_pkg::LEN_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      pattern_length_r <= pwdata[awm_pkg::LEN_W-1:0];
    end
  end

  assign prdata = reg_sel ? awm_pkg::DATA_W'(pattern_length_r) : '0;

  // front end: window delay line, text counter, splits each transaction
  // into count-table operations (leaving symbol first, then entering)
  awm_sequencer #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .WINDOW_MAX    (WINDOW_MAX)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .pattern_length (pattern_length_r),
    .uop            (uop),
    .uop_ready      (uop_ready)
  );

  // back end: count table read-modify-write with forwarding, running
  // absolute sum, match counter and the output register
  awm_count_unit #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_cnt (
    .clk       (clk),
    .rst_n     (rst_n),
    .uop       (uop),
    .uop_ready (uop_ready),
    .out_ch    (out_ch)
  );

endmodule
